>>> hw/rtl/dynamical_zeta_partial_sum_assert.svh
// Assertion macros used by the checker module.
`ifndef DYNAMICAL_ZETA_PARTIAL_SUM_ASSERT_SVH
`define DYNAMICAL_ZETA_PARTIAL_SUM_ASSERT_SVH

// Check cons in the same cycle as ante.
`define DZPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define DZPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/dzps_pkg.sv
package dzps_pkg;

  localparam int TERMS_DEF     = 55;
  localparam int FRAC_BITS_DEF = 48;

  localparam int IN_W  = 48;
  localparam int OUT_W = 42;
  localparam int EXP_W = 21;

  localparam logic [0:0] REG_EXPONENT = 1'b0;
  localparam logic [0:0] REG_MAP_MODE = 1'b1;

  localparam logic signed [EXP_W-1:0] EXPONENT_RESET = 21'sd65536;
  localparam logic                    MAP_MODE_RESET = 1'b1;
  localparam logic                    MODE_BERNOULLI = 1'b0;

  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [29:0] LN2_Q30   = 30'h2C5C85FE;
  localparam logic [33:0] GAIN_Q30  = 34'd652032874;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_LOG, S_LOGW, S_Y, S_YW, S_TM, S_TR, S_TQ, S_TC,
    S_PH, S_PHW, S_CORD, S_QUAD, S_MRE, S_ARE, S_MIM, S_AIM,
    S_MOD, S_DIV, S_DONE
  } state_t;

  typedef logic [32:0] log2_tab_t [64];
  typedef logic [30:0] arc_tab_t [30];
  typedef logic [32:0] recip_tab_t [16];

  // shift and subtract quotient, used only to build the constant tables
  function automatic longint unsigned cdiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int b;
    q = 0;
    r = 0;
    for (b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic log2_tab_t build_log2();
    log2_tab_t tab;
    longint unsigned m;
    longint unsigned fr;
    int p;
    int k;
    int n;
    tab[0] = '0;
    for (n = 1; n < 64; n++) begin
      p = 0;
      while ((n >> (p + 1)) != 0) p++;
      m  = (64'(n) << 30) >> p;
      fr = 0;
      for (k = 0; k < 30; k++) begin
        m  = (m * m) >> 30;
        fr = fr << 1;
        if (m >= (64'd1 << 31)) begin
          m  = m >> 1;
          fr = fr | 64'd1;
        end
      end
      tab[n] = 33'((64'(p) << 30) | fr);
    end
    return tab;
  endfunction

  function automatic arc_tab_t build_arc();
    arc_tab_t tab;
    longint acc;
    longint t;
    int i;
    int j;
    for (i = 0; i < 30; i++) begin
      if (i == 0) begin
        acc = 64'(PI_Q30) / 4;
      end else begin
        acc = 0;
        j   = 0;
        while (i * (2 * j + 1) <= 30) begin
          t   = longint'(cdiv(64'd1 << (30 - i * (2 * j + 1)), 64'(2 * j + 1)));
          acc = ((j & 1) != 0) ? acc - t : acc + t;
          j++;
        end
      end
      tab[i] = 31'(acc);
    end
    return tab;
  endfunction

  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    int i;
    for (i = 0; i < 16; i++) begin
      tab[i] = 33'(cdiv(64'd1 << 32, 64'(i + 1)));
    end
    return tab;
  endfunction

  localparam log2_tab_t  LOG2_TAB  = build_log2();
  localparam arc_tab_t   ARC_TAB   = build_arc();
  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

>>> hw/rtl/dynamical_zeta_partial_sum.sv
// Dynamical zeta partial sum: sum over n of n^-s * exp(2*pi*i*x_n).
// Configuration: write_enable/write_index/write_data set exponent (index 0,
// signed Q4.16) and map_mode (index 1); write only while busy is low.
// Input: a transaction is taken on a rising edge with start high and busy
// low; start_position is the Q0.48 start point. busy stays high until the
// result has been shown.
// Output: done is high for one cycle with sum_real, sum_imag (Q17.24),
// invalid and saturated valid in that cycle; the receiver cannot stall.
// Per transaction, all on one shared multiplier and sequencer, each term
//   runs log, exp2 setup, Taylor series with reciprocal division, phase,
//   CORDIC, quadrant, and scale and accumulate steps, plus a bit-serial
//   division per Gauss map step; Gauss mode ends early when x reaches zero.
// One transaction at a time; the next may start the cycle after done.
// Reset: exponent returns to 1.0, map_mode to Gauss, sequencer to idle.
module dynamical_zeta_partial_sum #(
  parameter int TERMS     = dzps_pkg::TERMS_DEF,
  parameter int FRAC_BITS = dzps_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [0:0]                         write_index,
  input  logic [dzps_pkg::EXP_W-1:0]         write_data,
  input  logic                               start,
  input  logic [dzps_pkg::IN_W-1:0]          start_position,
  output logic                               busy,
  output logic                               done,
  output logic signed [dzps_pkg::OUT_W-1:0]  sum_real,
  output logic signed [dzps_pkg::OUT_W-1:0]  sum_imag,
  output logic                               invalid,
  output logic                               saturated
);

  localparam int N_W  = $clog2(TERMS + 1);
  localparam int DC_W = $clog2(FRAC_BITS + 2);
  localparam int OW   = dzps_pkg::OUT_W;

  dzps_pkg::state_t state, state_next;

  logic signed [dzps_pkg::EXP_W-1:0] exponent;
  logic                              map_mode;

  logic [N_W-1:0]        n;
  logic [FRAC_BITS-1:0]  x;
  logic signed [9:0]     ip;
  logic [29:0]           fr;
  logic [29:0]           y;
  logic [30:0]           term;
  logic [30:0]           tsum;
  logic [30:0]           v;
  logic [3:0]            km1;
  logic [1:0]            qd;
  logic signed [33:0]    xr, yr, z;
  logic [4:0]            ci;
  logic signed [33:0]    cval, sval;
  logic signed [OW-1:0]  re, im;
  logic                  sat, bad;
  logic [FRAC_BITS-1:0]  rem;
  logic [FRAC_BITS-1:0]  quo;
  logic [DC_W-1:0]       dcnt;

  logic signed [33:0]    mul_a, mul_b;
  logic signed [67:0]    prod;

  logic [FRAC_BITS+47:0] x_ext;
  logic [FRAC_BITS+31:0] p_ext;
  logic [31:0]           phase;
  logic [31:0]           qsum;
  logic [31:0]           d;

  logic signed [67:0]    neg;
  logic [30:0]           q0;
  logic [35:0]           rr;
  logic [4:0]            k5;
  logic [30:0]           qf;

  logic signed [33:0]    dx, dy, arc;

  logic signed [9:0]     sc_r;
  logic [6:0]            kk;
  logic [5:0]            sh;
  logic signed [67:0]    mag;
  logic [67:0]           lim;
  logic signed [67:0]    shifted;
  logic signed [63:0]    res;
  logic signed [63:0]    acc_sum;
  logic signed [OW-1:0]  acc_sel;
  logic signed [OW-1:0]  acc_new;
  logic                  acc_clip;

  logic [FRAC_BITS:0]    r2;
  logic                  r_ge;

  assign x_ext = {start_position, FRAC_BITS'(0)};
  assign p_ext = {x, 32'd0};
  assign phase = p_ext[FRAC_BITS +: 32];
  assign qsum  = phase + 32'h2000_0000;
  assign d     = phase - {qsum[31:30], 30'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= dzps_pkg::EXPONENT_RESET;
      map_mode <= dzps_pkg::MAP_MODE_RESET;
    end else if (write_enable) begin
      case (write_index)
        dzps_pkg::REG_EXPONENT: exponent <= write_data;
        dzps_pkg::REG_MAP_MODE: map_mode <= write_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      dzps_pkg::S_LOG: begin
        mul_a = {{13{exponent[20]}}, exponent};
        mul_b = {1'b0, dzps_pkg::LOG2_TAB[6'(n)]};
      end
      dzps_pkg::S_Y: begin
        mul_a = {4'd0, fr};
        mul_b = {4'd0, dzps_pkg::LN2_Q30};
      end
      dzps_pkg::S_TM: begin
        mul_a = {3'd0, term};
        mul_b = {4'd0, y};
      end
      dzps_pkg::S_TQ: begin
        mul_a = {3'd0, v};
        mul_b = {1'b0, dzps_pkg::RECIP_TAB[km1]};
      end
      dzps_pkg::S_PH: begin
        mul_a = {{2{d[31]}}, d};
        mul_b = {2'd0, dzps_pkg::PI_Q30};
      end
      dzps_pkg::S_MRE: begin
        mul_a = {3'd0, tsum};
        mul_b = cval;
      end
      dzps_pkg::S_MIM: begin
        mul_a = {3'd0, tsum};
        mul_b = sval;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    neg  = -prod;
    q0   = prod[62:32];
    k5   = {1'b0, km1} + 5'd1;
    rr   = {5'd0, v} - (36'(q0) * 36'(k5));
    qf   = q0 + 31'(rr >= 36'(k5));
    dx   = yr >>> ci;
    dy   = xr >>> ci;
    arc  = {3'd0, dzps_pkg::ARC_TAB[ci]};
  end

  always_comb begin
    sc_r    = 10'sd36 - ip;
    kk      = 7'(-sc_r);
    sh      = (sc_r > 10'sd63) ? 6'd63 : sc_r[5:0];
    mag     = prod[67] ? -prod : prod;
    lim     = (68'd1 << 61) >> kk;
    shifted = prod >>> sh;
    if (!sc_r[9]) begin
      res = shifted[63:0];
    end else if (prod == '0) begin
      res = '0;
    end else if (kk > 7'd61 || $unsigned(mag) > lim) begin
      res = prod[67] ? -(64'sd1 <<< 61) : (64'sd1 <<< 61);
    end else begin
      shifted = prod <<< kk;
      res     = shifted[63:0];
    end
    acc_sel  = (state == dzps_pkg::S_ARE) ? re : im;
    acc_sum  = 64'(acc_sel) + res;
    acc_clip = 1'b0;
    acc_new  = acc_sum[OW-1:0];
    if (acc_sum > 64'((65'sd1 <<< (OW - 1)) - 65'sd1)) begin
      acc_new  = {1'b0, {(OW - 1){1'b1}}};
      acc_clip = 1'b1;
    end else if (acc_sum < -(64'sd1 <<< (OW - 1))) begin
      acc_new  = {1'b1, {(OW - 1){1'b0}}};
      acc_clip = 1'b1;
    end
  end

  always_comb begin
    if (state == dzps_pkg::S_MOD) begin
      r2 = {rem, dcnt == '0};
    end else begin
      r2 = {rem, 1'b0};
    end
    r_ge = r2 >= {1'b0, x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dzps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dzps_pkg::S_IDLE: if (start) state_next = dzps_pkg::S_LOG;
      dzps_pkg::S_LOG:  state_next = dzps_pkg::S_LOGW;
      dzps_pkg::S_LOGW: state_next = dzps_pkg::S_Y;
      dzps_pkg::S_Y:    state_next = dzps_pkg::S_YW;
      dzps_pkg::S_YW:   state_next = dzps_pkg::S_TM;
      dzps_pkg::S_TM:   state_next = dzps_pkg::S_TR;
      dzps_pkg::S_TR:   state_next = dzps_pkg::S_TQ;
      dzps_pkg::S_TQ:   state_next = dzps_pkg::S_TC;
      dzps_pkg::S_TC: begin
        state_next = (km1 == 4'd15) ? dzps_pkg::S_PH : dzps_pkg::S_TM;
      end
      dzps_pkg::S_PH:   state_next = dzps_pkg::S_PHW;
      dzps_pkg::S_PHW:  state_next = dzps_pkg::S_CORD;
      dzps_pkg::S_CORD: if (ci == 5'd29) state_next = dzps_pkg::S_QUAD;
      dzps_pkg::S_QUAD: state_next = dzps_pkg::S_MRE;
      dzps_pkg::S_MRE:  state_next = dzps_pkg::S_ARE;
      dzps_pkg::S_ARE:  state_next = dzps_pkg::S_MIM;
      dzps_pkg::S_MIM:  state_next = dzps_pkg::S_AIM;
      dzps_pkg::S_AIM: begin
        if (n == N_W'(TERMS)) begin
          state_next = dzps_pkg::S_DONE;
        end else if (map_mode == dzps_pkg::MODE_BERNOULLI) begin
          state_next = dzps_pkg::S_LOG;
        end else if (x == '0) begin
          state_next = dzps_pkg::S_DONE;
        end else begin
          state_next = dzps_pkg::S_MOD;
        end
      end
      dzps_pkg::S_MOD: if (dcnt == DC_W'(FRAC_BITS)) state_next = dzps_pkg::S_DIV;
      dzps_pkg::S_DIV: if (dcnt == DC_W'(FRAC_BITS - 1)) state_next = dzps_pkg::S_LOG;
      dzps_pkg::S_DONE: state_next = dzps_pkg::S_IDLE;
      default:          state_next = dzps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      dzps_pkg::S_IDLE: begin
        x   <= x_ext[48 +: FRAC_BITS];
        n   <= N_W'(1);
        re  <= '0;
        im  <= '0;
        sat <= 1'b0;
        bad <= 1'b0;
      end
      dzps_pkg::S_LOGW: begin
        ip <= neg[55:46];
        fr <= neg[45:16];
      end
      dzps_pkg::S_YW: begin
        y    <= prod[59:30];
        term <= dzps_pkg::ONE_Q30;
        tsum <= dzps_pkg::ONE_Q30;
        km1  <= '0;
      end
      dzps_pkg::S_TR: v <= prod[60:30];
      dzps_pkg::S_TC: begin
        term <= qf;
        tsum <= tsum + qf;
        km1  <= km1 + 4'd1;
      end
      dzps_pkg::S_PH: qd <= qsum[31:30];
      dzps_pkg::S_PHW: begin
        z  <= prod[64:31];
        xr <= dzps_pkg::GAIN_Q30;
        yr <= '0;
        ci <= '0;
      end
      dzps_pkg::S_CORD: begin
        if (!z[33]) begin
          xr <= xr - dx;
          yr <= yr + dy;
          z  <= z - arc;
        end else begin
          xr <= xr + dx;
          yr <= yr - dy;
          z  <= z + arc;
        end
        ci <= ci + 5'd1;
      end
      dzps_pkg::S_QUAD: begin
        case (qd)
          2'd1:    begin cval <= -yr; sval <= xr;  end
          2'd2:    begin cval <= -xr; sval <= -yr; end
          2'd3:    begin cval <= yr;  sval <= -xr; end
          default: begin cval <= xr;  sval <= yr;  end
        endcase
      end
      dzps_pkg::S_ARE: begin
        re  <= acc_new;
        sat <= sat | acc_clip;
      end
      dzps_pkg::S_AIM: begin
        im   <= acc_new;
        sat  <= sat | acc_clip;
        rem  <= '0;
        dcnt <= '0;
        if (n != N_W'(TERMS)) begin
          if (map_mode == dzps_pkg::MODE_BERNOULLI) begin
            x <= {x[FRAC_BITS-2:0], 1'b0};
            n <= n + N_W'(1);
          end else if (x == '0) begin
            bad <= 1'b1;
          end
        end
      end
      dzps_pkg::S_MOD: begin
        rem  <= r_ge ? FRAC_BITS'(r2 - {1'b0, x}) : FRAC_BITS'(r2);
        quo  <= '0;
        dcnt <= (dcnt == DC_W'(FRAC_BITS)) ? '0 : dcnt + DC_W'(1);
      end
      dzps_pkg::S_DIV: begin
        rem  <= r_ge ? FRAC_BITS'(r2 - {1'b0, x}) : FRAC_BITS'(r2);
        quo  <= {quo[FRAC_BITS-2:0], r_ge};
        dcnt <= dcnt + DC_W'(1);
        if (dcnt == DC_W'(FRAC_BITS - 1)) begin
          x <= {quo[FRAC_BITS-2:0], r_ge};
          n <= n + N_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign busy      = state != dzps_pkg::S_IDLE;
  assign done      = state == dzps_pkg::S_DONE;
  assign sum_real  = bad ? '0 : re;
  assign sum_imag  = bad ? '0 : im;
  assign invalid   = bad;
  assign saturated = sat & ~bad;

endmodule

>>> hw/rtl/dzps_checker.sv
`include "dynamical_zeta_partial_sum_assert.svh"

module dzps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [dzps_pkg::OUT_W-1:0] sum_real,
  input logic signed [dzps_pkg::OUT_W-1:0] sum_imag,
  input logic                              invalid,
  input logic                              saturated
);

  `DZPS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transaction accepted but not busy")
  `DZPS_ASSERT_SAME(a_done_busy, done, busy, "result shown while idle")
  `DZPS_ASSERT_NEXT(a_done_idle, done, !busy && !done, "busy or done held after result")
  `DZPS_ASSERT_SAME(a_invalid_zero, done && invalid,
                    sum_real == '0 && sum_imag == '0 && !saturated,
                    "invalid result with nonzero sums")

endmodule

bind dynamical_zeta_partial_sum dzps_checker u_dzps_checker (.*);
